[src/zip_end_record_locator_top_assert.svh]
// Assertion macros for the zip end record locator port checker.
`ifndef ZIP_END_RECORD_LOCATOR_TOP_ASSERT_SVH
`define ZIP_END_RECORD_LOCATOR_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define ZERL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Clocked assertion that also holds while reset is asserted.
`define ZERL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

[src/zerl_pkg.sv]
// Types and constants of the zip end record locator.
package zerl_pkg;

  localparam int unsigned RecordBytes = 22;
  localparam int unsigned MaxTail     = 65557;
  localparam int unsigned CountW      = 17;
  localparam int unsigned OffsetW     = 32;
  localparam int unsigned BaseW       = 64;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 40;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgAddrW    = 4;

  localparam logic [31:0]        EocdSignature = 32'h0605_4b50;
  localparam logic [CountW-1:0]  MaxTailCnt    = CountW'(MaxTail);
  localparam logic [CountW-1:0]  RecordCnt     = CountW'(RecordBytes);
  localparam logic [CountW-1:0]  TailLenReset  = CountW'(RecordBytes);

  typedef enum logic [1:0] {
    ST_UNIQUE    = 2'd0,
    ST_NONE      = 2'd1,
    ST_SEVERAL   = 2'd2,
    ST_COUNT_ERR = 2'd3
  } zerl_status_e;

  // Register select: paddr bit 3 (8-byte register stride).
  typedef enum logic {
    REG_TAIL_LENGTH = 1'b0,
    REG_TAIL_BASE   = 1'b1
  } zerl_reg_e;

  typedef struct packed {
    logic               hit;
    logic [OffsetW-1:0] dir_offset;
  } zerl_check_t;

endpackage

[src/zerl_record_check.sv]
// End-of-central-directory record test on one 22-byte window.
module zerl_record_check
  import zerl_pkg::*;
(
  input  logic [RecordBytes-1:0][7:0] rec_i,        // rec_i[0] is the oldest byte
  input  logic [CountW-1:0]           byte_count_i, // bytes seen including rec_i[21]
  input  logic [CountW-1:0]           tail_length_i,
  input  logic [BaseW-1:0]            tail_base_i,
  output zerl_check_t                 check_o
);

  logic [31:0]        sig;
  logic [15:0]        disk_num, disk_cd, ent_disk, ent_total, comment_len;
  logic [31:0]        dir_size, dir_off;
  logic [CountW-1:0]  position;
  logic [CountW:0]    end_pos;
  logic [32:0]        dir_end;
  logic [BaseW-1:0]   record_at;

  assign sig         = rec_i[3:0];
  assign disk_num    = rec_i[5:4];
  assign disk_cd     = rec_i[7:6];
  assign ent_disk    = rec_i[9:8];
  assign ent_total   = rec_i[11:10];
  assign dir_size    = rec_i[15:12];
  assign dir_off     = rec_i[19:16];
  assign comment_len = rec_i[21:20];

  // Record start within the tail; only meaningful once 22 bytes are in.
  assign position  = byte_count_i - RecordCnt;
  assign end_pos   = {1'b0, byte_count_i} + (CountW+1)'(comment_len);
  assign dir_end   = {1'b0, dir_off} + {1'b0, dir_size};
  assign record_at = tail_base_i + BaseW'(position);

  always_comb begin
    check_o.dir_offset = dir_off;
    check_o.hit = (sig == EocdSignature)
                & (end_pos == {1'b0, tail_length_i})
                & (disk_num == 16'h0) & (disk_cd == 16'h0)
                & (ent_disk == ent_total) & (ent_total != 16'hFFFF)
                & (dir_size != 32'hFFFF_FFFF) & (dir_off != 32'hFFFF_FFFF)
                & (BaseW'(dir_end) == record_at);
  end

endmodule

[src/zip_end_record_locator_top.sv]
// Top level of the zip end record locator: stream in, verdict out, APB registers.
//
// The block takes the tail of a ZIP archive one byte per word on the slave
// stream, oldest byte first, with tlast on the final byte. It keeps the last
// 21 bytes in a shift register and tests every full 22-byte window ending at
// the current byte as an end-of-central-directory record: signature, zero disk
// numbers, equal entry counts that are not 0xFFFF, size and offset not all
// ones, a comment that ends exactly at tail_length, and directory offset plus
// size equal to tail_base plus the record position (64-bit, wrapping). The
// whole test is one combinational pass on the incoming byte, so a byte is
// accepted on every cycle; the limit is the 64-bit position add and compare in
// that pass. One result word is produced per tail, registered as the tlast byte
// is accepted, and it is held in an output register. While that
// word waits for m_axis_tready the slave stream is stalled; a word taken by
// m_axis_tready frees the register in the same cycle, so bytes keep flowing
// back to back when the sink is ready. Status is 0 for exactly one qualifying
// record (directory offset returned), 1 for none, 2 for two or more, 3 when the
// byte count differs from tail_length or exceeds 65557 bytes; any nonzero status
// returns offset 0. The user must write tail_length (0x0) and tail_base (0x8)
// through APB only while no tail is in flight; the block does not enforce it.
module zip_end_record_locator_top
  import zerl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] tail_byte
  input  logic                s_axis_tlast,   // last
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [1:0] status, [33:2] directory_offset,
                                              // [39:34] zero
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // ---------------------------------------------------------------- config
  logic [CountW-1:0] tail_length_q;
  logic [BaseW-1:0]  tail_base_q;
  logic              cfg_wr;
  zerl_reg_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = zerl_reg_e'(paddr[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_length_q <= TailLenReset;
      tail_base_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_TAIL_LENGTH: tail_length_q <= pwdata[CountW-1:0];
        REG_TAIL_BASE:   tail_base_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_TAIL_LENGTH: prdata = CfgDataW'(tail_length_q);
      REG_TAIL_BASE:   prdata = tail_base_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  logic                  in_acc;
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;

  // Output register empties this cycle or is already empty.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // 21-byte history, oldest at index 0.
  logic [RecordBytes-2:0][7:0] window_q;
  logic [CountW-1:0]           count_q, count_d;
  logic [1:0]                  match_cnt_q, match_cnt_d;
  logic [OffsetW-1:0]          match_off_q, match_off_d;
  logic [RecordBytes-1:0][7:0] rec;
  zerl_check_t                 check;
  logic                        test_en;
  zerl_status_e                status;
  logic [OffsetW-1:0]          res_off;

  assign rec = {s_axis_tdata, window_q};

  zerl_record_check u_check (
    .rec_i         (rec),
    .byte_count_i  (count_d),
    .tail_length_i (tail_length_q),
    .tail_base_i   (tail_base_q),
    .check_o       (check)
  );

  always_comb begin
    // count saturates one above the largest tail
    count_d     = (count_q <= MaxTailCnt) ? count_q + 1'b1 : count_q;
    test_en     = (count_d >= RecordCnt) & (count_d <= MaxTailCnt);
    match_cnt_d = match_cnt_q;
    match_off_d = match_off_q;
    if (test_en && check.hit) begin
      match_off_d = check.dir_offset;
      if (match_cnt_q != 2'd2) match_cnt_d = match_cnt_q + 1'b1;
    end
    // verdict for a tlast byte; count error wins
    res_off = '0;
    if ((count_d != tail_length_q) || (count_d > MaxTailCnt)) begin
      status = ST_COUNT_ERR;
    end else begin
      case (match_cnt_d)
        2'd0:    status = ST_NONE;
        2'd1: begin
          status  = ST_UNIQUE;
          res_off = match_off_d;
        end
        default: status = ST_SEVERAL;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      window_q    <= rec[RecordBytes-1:1];
      match_off_q <= match_off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      match_cnt_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        count_q     <= '0;
        match_cnt_q <= '0;
      end else begin
        count_q     <= count_d;
        match_cnt_q <= match_cnt_d;
      end
    end
  end

  // ---------------------------------------------------------------- output side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      out_data_q <= {(OutDataW-OffsetW-2)'(0), res_off, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[src/zerl_port_checker.sv]
// Port-level assertions for the zip end record locator, bound to the top level.
`include "zip_end_record_locator_top_assert.svh"

module zerl_port_checker
  import zerl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result word holds
  `ZERL_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // a new result follows only a tlast byte
  `ZERL_ASSERT(a_out_after_last, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))

  // offset is zero unless the record is unique
  `ZERL_ASSERT(a_off_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] != ST_UNIQUE) |-> (m_axis_tdata[OffsetW+1:2] == '0))

  // input never stalls while the output register is empty
  `ZERL_ASSERT(a_in_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)

  // no result word on the edge after one seen in reset
  `ZERL_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind zip_end_record_locator_top zerl_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the zip end record locator: archive tails in, verdicts checked.
module testbench;
  import zerl_pkg::*;

  // one word on the slave stream
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } tail_word_t;

  // one verdict word on the master stream
  typedef struct packed {
    zerl_status_e status;
    logic [31:0]  dir_offset;
  } verdict_t;

  // ways to spoil the first record of a tail
  typedef enum int {
    FLAW_NONE,
    FLAW_SIGNATURE,
    FLAW_DISK,
    FLAW_COUNTS,
    FLAW_FULL_ENTRIES,
    FLAW_SIZE_ONES,
    FLAW_OFFSET_ONES,
    FLAW_COMMENT,
    FLAW_SUM,
    FLAW_COUNT
  } flaw_e;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [CfgAddrW-1:0] paddr          = '0;
  logic [CfgDataW-1:0] pwdata         = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  zip_end_record_locator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tail_word_t  byte_q[$];
  verdict_t    verdict_q[$];
  int unsigned mismatches     = 0;
  int unsigned queued_bytes   = 0;
  int unsigned send_gap_pct   = 28;
  int unsigned sink_stall_pct = 84;
  bit          in_taken       = 1'b0;

  // shadow of the block: registers and per-tail scan state
  logic [CountW-1:0]  cfg_len    = TailLenReset;
  logic [BaseW-1:0]   cfg_base   = '0;
  logic [20:0][7:0]   win_q      = '0;   // previous 21 bytes, oldest in [0]
  logic [CountW-1:0]  seen_n     = '0;
  logic [1:0]         hits_n     = '0;
  logic [31:0]        hit_offset = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_error(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // true when the 22-byte window rec, starting at tail position pos, is a valid record
  function automatic bit record_matches(input logic [21:0][7:0] rec, input int unsigned pos);
    logic [31:0] sig, dsize, doff;
    logic [15:0] disk_a, disk_b, ents, tot, com;
    logic [63:0] at;
    {com, doff, dsize, tot, ents, disk_b, disk_a, sig} = rec;
    at = cfg_base + 64'(pos);
    return sig == EocdSignature
        && pos + RecordBytes + 32'(com) == 32'(cfg_len)
        && disk_a == 16'd0 && disk_b == 16'd0
        && ents == tot && tot != 16'hFFFF
        && dsize != 32'hFFFF_FFFF && doff != 32'hFFFF_FFFF
        && {32'd0, doff} + {32'd0, dsize} == at;
  endfunction

  // advance the shadow scan by one accepted byte; a final byte yields a verdict
  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    logic [21:0][7:0] rec;
    verdict_t v;
    rec = {b, win_q};
    if (seen_n <= MaxTailCnt) seen_n++;
    if (seen_n >= RecordCnt && seen_n <= MaxTailCnt) begin
      if (record_matches(rec, 32'(seen_n - RecordCnt))) begin
        hit_offset = {rec[19], rec[18], rec[17], rec[16]};
        if (hits_n < 2'd2) hits_n++;
      end
    end
    win_q = rec[21:1];
    if (fin) begin
      v.dir_offset = '0;
      if (seen_n != cfg_len || seen_n > MaxTailCnt) v.status = ST_COUNT_ERR;
      else if (hits_n == 2'd1) begin
        v.status = ST_UNIQUE;
        v.dir_offset = hit_offset;
      end else if (hits_n == 2'd0) v.status = ST_NONE;
      else v.status = ST_SEVERAL;
      verdict_q.push_back(v);
      win_q = '0;
      seen_n = '0;
      hits_n = '0;
      hit_offset = '0;
    end
  endfunction

  // monitor: track accepted bytes, check every verdict word
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) absorb_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected verdict word %h", m_axis_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[1:0] !== want.status)
            flag_error($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.status));
          if (m_axis_tdata[33:2] !== want.dir_offset)
            flag_error($sformatf("directory offset %h, want %h",
                                 m_axis_tdata[33:2], want.dir_offset));
        end
      end
    end
  end

  // driver: random gaps on the byte stream, random stalls on the verdict stream
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      if (!s_axis_tvalid || in_taken) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q[0].data;
          s_axis_tlast  <= byte_q[0].is_last;
          void'(byte_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input zerl_reg_e sel, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_TAIL_LENGTH) cfg_len = value[CountW-1:0];
    else cfg_base = value;
  endtask

  // wait until the stream is empty and every verdict is in, then let the block settle
  task automatic wait_idle();
    while (byte_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Build one tail of n_bytes random bytes with up to n_records records laid out for the
  // current registers (comment ending at tail_length, offset + size at the record's spot).
  // The first record may be spoiled; far_first puts it at the lowest legal position.
  task automatic queue_tail(input int n_bytes, input int n_records, input flaw_e flaw,
                            input bit far_first);
    logic [7:0]       tail_b[];
    logic [21:0][7:0] rec;
    logic [63:0]      at, smin, smax, pick;
    logic [31:0]      sig, size_v, off_v;
    logic [15:0]      disk_a, disk_b, ents, tot, com;
    int               hi, lo, p, gap, r, k;
    tail_b = new[n_bytes];
    foreach (tail_b[i]) tail_b[i] = 8'($urandom);
    hi = int'(cfg_len) - 22;
    if (hi > n_bytes - 22) hi = n_bytes - 22;
    lo = int'(cfg_len) - 22 - 65535;
    if (lo < 0) lo = 0;
    p = hi;
    for (r = 0; r < n_records; r++) begin
      if (r == 0) begin
        gap = hi - lo;
        if (gap > 30) gap = 30;
        if (gap < 0) gap = 0;
        p = far_first ? lo : hi - int'($urandom_range(0, gap));
      end else begin
        p = p - 22 - int'($urandom_range(0, 12));
      end
      if (p < lo || p > n_bytes - 22) break;
      at = cfg_base + 64'(p);
      if (at <= 64'h1_FFFF_FFFC) begin
        smin = (at > 64'hFFFF_FFFE) ? at - 64'hFFFF_FFFE : 64'd0;
        smax = (at < 64'hFFFF_FFFE) ? at : 64'hFFFF_FFFE;
        pick = ($urandom_range(0, 7) == 0) ? smin
             : smin + ({$urandom, $urandom} % (smax - smin + 64'd1));
        size_v = pick[31:0];
        off_v  = 32'(at - pick);
      end else begin
        // no split can reach this position: the record cannot qualify
        size_v = $urandom;
        off_v  = $urandom;
      end
      sig    = EocdSignature;
      disk_a = '0;
      disk_b = '0;
      ents   = 16'($urandom_range(0, 16'hFFFE));
      tot    = ents;
      com    = 16'(int'(cfg_len) - p - 22);
      if (r == 0) begin
        case (flaw)
          FLAW_SIGNATURE: begin
            k = int'($urandom_range(0, 31));
            sig[k] = ~sig[k];
          end
          FLAW_DISK: begin
            if ($urandom_range(0, 1) != 0) disk_a[$urandom_range(0, 15)] = 1'b1;
            else disk_b[$urandom_range(0, 15)] = 1'b1;
          end
          FLAW_COUNTS:       tot = ents ^ (16'd1 << $urandom_range(0, 15));
          FLAW_FULL_ENTRIES: begin
            ents = 16'hFFFF;
            tot  = 16'hFFFF;
          end
          FLAW_SIZE_ONES:    size_v = 32'hFFFF_FFFF;
          FLAW_OFFSET_ONES:  off_v = 32'hFFFF_FFFF;
          FLAW_COMMENT:      com = ($urandom_range(0, 1) != 0) ? com + 16'd1 : com - 16'd1;
          FLAW_SUM:          off_v = off_v + 32'd1;
          default: ;
        endcase
      end
      rec = {com, off_v, size_v, tot, ents, disk_b, disk_a, sig};
      for (k = 0; k < 22; k++) tail_b[p + k] = rec[k];
    end
    for (k = 0; k < n_bytes; k++)
      byte_q.push_back('{data: tail_b[k], is_last: (k == n_bytes - 1)});
    queued_bytes += n_bytes;
  endtask

  // idling follows how far the stimulus has got
  task automatic pick_idling();
    if (queued_bytes < 450) begin
      send_gap_pct   = 28;
      sink_stall_pct = 84;
    end else if (queued_bytes < 900) begin
      send_gap_pct   = 84;
      sink_stall_pct = 28;
    end else begin
      send_gap_pct   = 0;
      sink_stall_pct = 0;
    end
  endtask

  initial begin
    int          n_tails, n_bytes, n_rec, t, f;
    int unsigned roll;
    logic [16:0] len_v;
    logic [63:0] base_v;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, on reset registers (22 bytes, base 0): exact record, no record, short, long
    queue_tail(22, 1, FLAW_NONE, 1'b0);
    queue_tail(22, 0, FLAW_NONE, 1'b0);
    queue_tail(1, 0, FLAW_NONE, 1'b0);
    queue_tail(23, 1, FLAW_NONE, 1'b0);
    // each rule broken once
    for (f = FLAW_SIGNATURE; f < FLAW_COUNT; f++) queue_tail(22, 1, flaw_e'(f), 1'b0);
    wait_idle();

    // position sum wrapping past 2^64
    write_reg(REG_TAIL_BASE, 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20)));
    write_reg(REG_TAIL_LENGTH, 64'd50);
    @(posedge clk_i);
    queue_tail(50, 1, FLAW_NONE, 1'b0);
    wait_idle();

    // tails built with up to two and up to three records
    write_reg(REG_TAIL_BASE, 64'd0);
    write_reg(REG_TAIL_LENGTH, 64'd70);
    @(posedge clk_i);
    queue_tail(70, 2, FLAW_NONE, 1'b0);
    queue_tail(70, 3, FLAW_NONE, 1'b0);
    wait_idle();

    // random phases: new registers, then a few tails back to back
    while (queued_bytes < 1350) begin
      pick_idling();
      roll = $urandom_range(0, 99);
      if (roll < 60) len_v = 17'($urandom_range(22, 60));
      else if (roll < 75) len_v = 17'($urandom_range(61, 200));
      else if (roll < 85) len_v = 17'($urandom_range(0, 21));
      else len_v = 17'($urandom);
      case ($urandom_range(0, 9))
        0:       base_v = '0;
        1:       base_v = '1;
        2:       base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 60));
        3:       base_v = {$urandom, $urandom};
        4:       base_v = {32'd0, $urandom};
        5:       base_v = 64'h1_FFFF_FF00 + 64'($urandom_range(0, 16'h200));
        default: base_v = 64'($urandom_range(0, 100000));
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_TAIL_BASE, base_v);
      // upper pwdata bits carry junk now and then; only 17 bits are kept
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_TAIL_LENGTH, {$urandom, 15'($urandom), len_v});
      else
        write_reg(REG_TAIL_LENGTH, 64'(len_v));
      @(posedge clk_i);
      n_tails = $urandom_range(1, 5);
      for (t = 0; t < n_tails; t++) begin
        if (cfg_len > 17'd200) n_bytes = $urandom_range(1, 80);
        else if ($urandom_range(0, 99) < 85) n_bytes = int'(cfg_len);
        else n_bytes = int'(cfg_len) + ($urandom_range(0, 1) != 0 ? 1 : -1)
                       * int'($urandom_range(1, 3));
        if (n_bytes < 1) n_bytes = 1;
        roll = $urandom_range(0, 99);
        n_rec = (roll < 15) ? 0 : (roll < 80) ? 1 : (roll < 92) ? 2 : 3;
        if ($urandom_range(0, 1) != 0) queue_tail(n_bytes, n_rec, FLAW_NONE, 1'b0);
        else queue_tail(n_bytes, n_rec, flaw_e'($urandom_range(FLAW_SIGNATURE,
                                                               FLAW_COUNT - 1)),
                        $urandom_range(0, 7) == 0);
      end
      wait_idle();
    end

    // largest register value against a short tail
    write_reg(REG_TAIL_LENGTH, 64'h1_FFFF);
    @(posedge clk_i);
    queue_tail(30, 1, FLAW_NONE, 1'b0);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_800_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
